### rtl/fssd_pkg.sv
package fssd_pkg;

  localparam int unsigned ChannelsDefault = 256;

  localparam logic [7:0] SyncByte   = 8'hAA;
  localparam logic [7:0] HdrMask    = 8'hFC;
  localparam logic [7:0] HdrMatch   = 8'h80;
  localparam logic [7:0] TagHiMask  = 8'h03;
  localparam logic [7:0] GainMask   = 8'hC0;
  localparam logic [7:0] RawHiMask  = 8'h3F;

  localparam int unsigned ValueW = 46;

  typedef struct packed {
    logic       emit;
    logic [7:0] channel;
    logic       last;
    logic [9:0] tag;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
  } sample_evt_t;

  function automatic logic [ValueW-1:0] sample_value(input logic [7:0] d0,
                                                     input logic [7:0] d1,
                                                     input logic [7:0] d2);
    logic [1:0]        gain;
    logic [21:0]       raw;
    logic [ValueW-1:0] val;
    gain = 2'((d0 & GainMask) >> 6);
    raw  = {6'(d0 & RawHiMask), d1, d2};
    case (gain)
      2'd0:    val = {raw, 24'b0};
      2'd1:    val = {8'b0, raw, 16'b0};
      2'd2:    val = {16'b0, raw, 8'b0};
      default: val = {24'b0, raw};
    endcase
    return val;
  endfunction

endpackage

### rtl/frame_sync_sample_decoder.sv
// Byte-stream frame decoder: hunts for sync 0xAA plus a header byte 100000xx,
// then counts fixed frames of a 3-byte header and CHANNELS 3-byte samples,
// emitting channel, 10-bit ms tag, 46-bit scaled value and a last flag per
// sample. One byte is transferred per cycle while the output side keeps up; a
// sample is loaded into an output register at the edge that takes its third
// byte; input stalls while that register holds a sample with out_ready_i low.
// restart_i (transferred with a byte) drops lock and resumes hunting.
module frame_sync_sample_decoder #(
  parameter int unsigned CHANNELS = fssd_pkg::ChannelsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        restart_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  channel_o,
  output logic [fssd_pkg::ValueW-1:0] sample_value_o,
  output logic [9:0]                  frame_ms_o,
  output logic                        last_in_frame_o
);
  import fssd_pkg::*;

  logic        take;
  sample_evt_t evt;

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  fssd_framer #(
    .CHANNELS(CHANNELS)
  ) u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .data_byte_i(data_byte_i),
    .restart_i  (restart_i),
    .evt_o      (evt)
  );

  fssd_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .evt_i          (evt),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .channel_o      (channel_o),
    .sample_value_o (sample_value_o),
    .frame_ms_o     (frame_ms_o),
    .last_in_frame_o(last_in_frame_o)
  );

endmodule

### rtl/fssd_framer.sv
module fssd_framer #(
  parameter int unsigned CHANNELS = fssd_pkg::ChannelsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   restart_i,
  output fssd_pkg::sample_evt_t  evt_o
);
  import fssd_pkg::*;

  localparam int unsigned CntW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(CHANNELS - 1);

  localparam logic [1:0] ModeHunt   = 2'd0;
  localparam logic [1:0] ModeTagLow = 2'd1;
  localparam logic [1:0] ModeLocked = 2'd2;

  logic [1:0]      mode_q, mode_d;
  logic            sync_q, sync_d;
  logic            hdr_q, hdr_d;
  logic [1:0]      idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [9:0]      tag_q, tag_d;
  logic [7:0]      d0_q, d0_d;
  logic [7:0]      d1_q, d1_d;
  logic            last;
  logic [CntW+7:0] cnt_ext;

  assign last    = (cnt_q == LastCnt);
  assign cnt_ext = {8'b0, cnt_q};

  always_comb begin
    mode_d = mode_q;
    sync_d = sync_q;
    hdr_d  = hdr_q;
    idx_d  = idx_q;
    cnt_d  = cnt_q;
    tag_d  = tag_q;
    d0_d   = d0_q;
    d1_d   = d1_q;
    evt_o  = '0;
    evt_o.channel = cnt_ext[7:0];
    evt_o.last    = last;
    evt_o.tag     = tag_q;
    evt_o.d0      = d0_q;
    evt_o.d1      = d1_q;
    evt_o.d2      = data_byte_i;
    if (restart_i) begin
      mode_d = ModeHunt;
      sync_d = 1'b0;
      hdr_d  = 1'b1;
      idx_d  = '0;
      cnt_d  = '0;
      tag_d  = '0;
    end else begin
      unique case (mode_q)
        ModeTagLow: begin
          tag_d  = {tag_q[9:8], data_byte_i};
          mode_d = ModeLocked;
          hdr_d  = 1'b0;
          idx_d  = '0;
          cnt_d  = '0;
          sync_d = 1'b0;
        end
        ModeLocked: begin
          if (hdr_q) begin
            if (idx_q == 2'd1) begin
              tag_d = {2'(data_byte_i & TagHiMask), tag_q[7:0]};
            end
            if (idx_q == 2'd2) begin
              tag_d = {tag_q[9:8], data_byte_i};
              hdr_d = 1'b0;
              idx_d = '0;
              cnt_d = '0;
            end else begin
              idx_d = idx_q + 2'd1;
            end
          end else begin
            if (idx_q == 2'd0) begin
              d0_d  = data_byte_i;
              idx_d = 2'd1;
            end else if (idx_q == 2'd1) begin
              d1_d  = data_byte_i;
              idx_d = 2'd2;
            end else begin
              evt_o.emit = 1'b1;
              idx_d      = '0;
              if (last) begin
                hdr_d = 1'b1;
                cnt_d = '0;
              end else begin
                cnt_d = cnt_q + 1'b1;
              end
            end
          end
        end
        default: begin
          mode_d = ModeHunt;
          if (sync_q && ((data_byte_i & HdrMask) == HdrMatch)) begin
            tag_d  = {2'(data_byte_i & TagHiMask), tag_q[7:0]};
            mode_d = ModeTagLow;
            sync_d = 1'b0;
          end else begin
            sync_d = (data_byte_i == SyncByte);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeHunt;
      sync_q <= 1'b0;
      hdr_q  <= 1'b1;
      idx_q  <= '0;
      cnt_q  <= '0;
      tag_q  <= '0;
    end else if (take_i) begin
      mode_q <= mode_d;
      sync_q <= sync_d;
      hdr_q  <= hdr_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      tag_q  <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      d0_q <= d0_d;
      d1_q <= d1_d;
    end
  end

endmodule

### rtl/fssd_out_stage.sv
module fssd_out_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  fssd_pkg::sample_evt_t         evt_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [7:0]                    channel_o,
  output logic [fssd_pkg::ValueW-1:0]   sample_value_o,
  output logic [9:0]                    frame_ms_o,
  output logic                          last_in_frame_o
);
  import fssd_pkg::*;

  logic              valid_q;
  logic              load;
  logic [7:0]        channel_q;
  logic [ValueW-1:0] value_q;
  logic [9:0]        ms_q;
  logic              last_q;

  assign load = take_i && evt_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      channel_q <= evt_i.channel;
      value_q   <= sample_value(evt_i.d0, evt_i.d1, evt_i.d2);
      ms_q      <= evt_i.tag;
      last_q    <= evt_i.last;
    end
  end

  assign out_valid_o     = valid_q;
  assign channel_o       = channel_q;
  assign sample_value_o  = value_q;
  assign frame_ms_o      = ms_q;
  assign last_in_frame_o = last_q;

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fssd_pkg::*;

  localparam int unsigned NumChannels = ChannelsDefault;
  localparam int unsigned FrameBytes  = 3 + 3 * NumChannels;
  localparam int unsigned RandomBytes = 48;
  localparam int unsigned CycleLimit  = 400000;

  typedef enum logic [1:0] {
    Hunting = 2'd0,
    TagLow  = 2'd1,
    Locked  = 2'd2
  } lock_mode_e;

  typedef enum int {
    ReadyAlways,
    ReadyCoin,
    ReadyMostly,
    ReadyPeriodic
  } ready_pattern_e;

  typedef struct packed {
    logic [7:0]        channel;
    logic [ValueW-1:0] value;
    logic [9:0]        ms_tag;
    logic              last;
  } sample_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        data_byte_i;
  logic              restart_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [7:0]        channel_o;
  logic [ValueW-1:0] sample_value_o;
  logic [9:0]        frame_ms_o;
  logic              last_in_frame_o;

  frame_sync_sample_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .channel_o      (channel_o),
    .sample_value_o (sample_value_o),
    .frame_ms_o     (frame_ms_o),
    .last_in_frame_o(last_in_frame_o)
  );

  // decoder state mirror
  lock_mode_e  lock_mode;
  logic        prev_sync;
  int unsigned frame_pos;
  logic [9:0]  ms_tag;
  logic [15:0] partial;
  int unsigned chan_idx;

  sample_t     pending_samples[$];
  sample_t     want;

  int unsigned cycle_count;
  int unsigned err_count;
  int unsigned bytes_sent;
  int unsigned restarts_sent;
  int unsigned samples_checked;
  int unsigned frames_closed;
  int unsigned burst_left;
  int unsigned idle_len;

  ready_pattern_e ready_pattern;
  int unsigned    pattern_left;

  initial begin
    clk_i = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d samples still pending", $time, pending_samples.size());
      $display("frame_sync_sample_decoder test failed");
      $finish;
    end
  end

  task automatic clear_decoder();
    lock_mode = Hunting;
    prev_sync = 1'b0;
    frame_pos = 0;
    ms_tag    = '0;
    partial   = '0;
    chan_idx  = 0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic rs);
    logic [1:0]        gain;
    logic [21:0]       raw;
    logic [ValueW-1:0] val;
    sample_t           s;
    if (rs) begin
      clear_decoder();
    end else begin
      case (lock_mode)
        TagLow: begin
          ms_tag[7:0] = b;
          lock_mode   = Locked;
          frame_pos   = 3;
          chan_idx    = 0;
          partial     = '0;
          prev_sync   = 1'b0;
        end
        Locked: begin
          if (frame_pos < 3) begin
            if (frame_pos == 1) ms_tag[9:8] = b[1:0];
            else if (frame_pos == 2) ms_tag[7:0] = b;
            frame_pos++;
            if (frame_pos == 3) begin
              chan_idx = 0;
              partial  = '0;
            end
          end else if ((frame_pos - 3) % 3 == 0) begin
            partial = {b, 8'h00};
            frame_pos++;
          end else if ((frame_pos - 3) % 3 == 1) begin
            partial[7:0] = b;
            frame_pos++;
          end else begin
            gain      = partial[15:14];
            raw       = {partial[13:8], partial[7:0], b};
            val       = {24'b0, raw} << (8 * (3 - gain));
            s.channel = chan_idx[7:0];
            s.value   = val;
            s.ms_tag  = ms_tag;
            s.last    = (chan_idx >= NumChannels - 1);
            pending_samples.push_back(s);
            frame_pos++;
            if (s.last || frame_pos >= FrameBytes) begin
              frame_pos = 0;
              chan_idx  = 0;
            end else begin
              chan_idx++;
            end
            partial = '0;
          end
        end
        default: begin
          lock_mode = Hunting;
          if (prev_sync && (b & HdrMask) == HdrMatch) begin
            ms_tag[9:8] = b[1:0];
            lock_mode   = TagLow;
            prev_sync   = 1'b0;
          end else begin
            prev_sync = (b == SyncByte);
          end
        end
      endcase
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic rs = 1'b0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      idle_len   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end else begin
      idle_len = 0;
    end
    repeat (idle_len) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    restart_i   <= rs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_byte(b, rs);
    burst_left--;
    if (rs) restarts_sent++;
    else bytes_sent++;
  endtask

  task automatic drain_pause();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_sync(input logic [9:0] tag);
    send_byte(SyncByte);
    send_byte(HdrMatch | {6'b0, tag[9:8]});
    send_byte(tag[7:0]);
  endtask

  task automatic send_sample(input logic [7:0] d0, input logic [7:0] d1, input logic [7:0] d2);
    send_byte(d0);
    send_byte(d1);
    send_byte(d2);
  endtask

  function automatic logic [7:0] bad_header();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ((b & HdrMask) == HdrMatch) b ^= 8'h40;
    return b;
  endfunction

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (pattern_left == 0) begin
      ready_pattern = ready_pattern_e'($urandom_range(0, 3));
      pattern_left  = $urandom_range(20, 300);
    end
    pattern_left--;
    case (ready_pattern)
      ReadyAlways:  out_ready_i <= 1'b1;
      ReadyCoin:    out_ready_i <= 1'($urandom_range(0, 1));
      ReadyMostly:  out_ready_i <= ($urandom_range(0, 7) != 0);
      default:      out_ready_i <= (cycle_count % 16 < 10);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        err_count++;
        $display("%0t: unexpected sample, expected none, got ch %0d value %h ms %0d last %0b",
                 $time, channel_o, sample_value_o, frame_ms_o, last_in_frame_o);
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (want.last) frames_closed++;
        if (channel_o !== want.channel) begin
          err_count++;
          $display("%0t: channel mismatch, expected %0d, got %0d",
                   $time, want.channel, channel_o);
        end
        if (sample_value_o !== want.value) begin
          err_count++;
          $display("%0t: sample_value mismatch, expected %h, got %h",
                   $time, want.value, sample_value_o);
        end
        if (frame_ms_o !== want.ms_tag) begin
          err_count++;
          $display("%0t: frame_ms mismatch, expected %0d, got %0d",
                   $time, want.ms_tag, frame_ms_o);
        end
        if (last_in_frame_o !== want.last) begin
          err_count++;
          $display("%0t: last_in_frame mismatch, expected %0b, got %0b",
                   $time, want.last, last_in_frame_o);
        end
      end
    end
  end

  // no lock from lone headers, bad headers or a sync cut by restart; a doubled sync still locks
  task automatic test_sync_hunting();
    send_byte(8'h80);
    send_byte(SyncByte);
    send_byte(8'h7F);
    send_byte(SyncByte);
    send_byte(8'hFC);
    send_byte(SyncByte);
    send_byte(8'h84);
    send_byte(SyncByte);
    send_byte(8'h00);
    send_byte(SyncByte, 1'b1);
    send_byte(8'h80);
    send_byte(SyncByte);
    send_byte(SyncByte);
    send_byte(8'h83);
    send_byte(8'h00, 1'b1);
  endtask

  // all gains with full-scale raw values, a zero sample and raw one at gain 3, tag at its maximum
  task automatic test_sample_extremes();
    send_sync(10'h3FF);
    send_sample(8'h3F, 8'hFF, 8'hFF);
    send_sample(8'h7F, 8'hFF, 8'hFF);
    send_sample(8'hBF, 8'hFF, 8'hFF);
    send_sample(8'hFF, 8'hFF, 8'hFF);
    send_sample(8'h00, 8'h00, 8'h00);
    send_sample(8'hC0, 8'h00, 8'h01);
  endtask

  task automatic test_restart_mid_sample();
    send_byte(8'h12);
    send_byte(8'h34, 1'b1);
    send_byte(8'h56);
    send_sync(10'h000);
    send_sample(8'h40, 8'h55, 8'hAA);
    send_byte(SyncByte);
    send_byte(8'h81, 1'b1);
    send_sync(10'h2A5);
    send_sample(8'h95, 8'h6A, 8'h5A);
  endtask

  // one whole frame, then an unchecked random header and the first sample after it
  task automatic test_frame_wrap();
    send_byte(8'h00, 1'b1);
    send_sync(10'($urandom_range(0, 1023)));
    repeat (FrameBytes + 3) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_streams();
    int unsigned start_bytes;
    int unsigned body_len;
    int unsigned kind;
    logic [7:0]  b;
    logic        paused;
    start_bytes = bytes_sent;
    paused      = 1'b0;
    while (bytes_sent - start_bytes < RandomBytes) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
        send_sync(10'($urandom_range(0, 1023)));
        body_len = $urandom_range(0, 30);
        repeat (body_len) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 16)) begin
          b = ($urandom_range(0, 3) == 0) ? SyncByte : 8'($urandom_range(0, 255));
          send_byte(b);
        end
      end else begin
        send_byte(SyncByte);
        if ($urandom_range(0, 1)) begin
          send_byte(bad_header());
        end else begin
          send_byte(HdrMatch | 8'($urandom_range(0, 3)));
          if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
          end
          send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
      end
      if (!paused && bytes_sent - start_bytes >= RandomBytes / 2) begin
        paused = 1'b1;
        drain_pause();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    restart_i     = 1'b0;
    out_ready_i   = 1'b0;
    cycle_count   = 0;
    err_count     = 0;
    bytes_sent    = 0;
    restarts_sent = 0;
    samples_checked = 0;
    frames_closed = 0;
    burst_left    = 0;
    pattern_left  = 0;
    clear_decoder();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_sync_hunting();
    test_sample_extremes();
    test_restart_mid_sample();
    test_frame_wrap();
    test_random_streams();

    drain_pause();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d stream bytes and %0d restarts; checked %0d samples across %0d frame ends.",
             bytes_sent, restarts_sent, samples_checked, frames_closed);
    if (err_count == 0) begin
      $display("frame_sync_sample_decoder test passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("frame_sync_sample_decoder test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fssd_pkg.sv
rtl/fssd_framer.sv
rtl/fssd_out_stage.sv
rtl/frame_sync_sample_decoder.sv
bench/testbench.sv
